### src/mtg_pkg.sv
// Package: shared constants and types for the MT19937 generator.
package mtg_pkg;
  localparam int unsigned Words = 624;
  localparam int unsigned ShiftOfs = 397;
  localparam int unsigned IdxW = 10;
  localparam int unsigned DefKeyDepth = 64;
  localparam logic [31:0] TwistXor = 32'h9908b0df;
  localparam logic [31:0] HiBit = 32'h80000000;
  localparam logic [31:0] LoBits = 32'h7fffffff;
  localparam logic [31:0] MulSeed = 32'd1812433253;
  localparam logic [31:0] MulMixA = 32'd1664525;
  localparam logic [31:0] MulMixB = 32'd1566083941;
  localparam logic [31:0] ArraySeed = 32'd19650218;
  localparam logic [31:0] SeedReset = 32'd5489;
  localparam logic [31:0] TemperB = 32'h9d2c5680;
  localparam logic [31:0] TemperC = 32'hefc60000;

  typedef enum logic {
    OpNext = 1'b0,
    OpKey  = 1'b1
  } op_e;

  // One classified command handed from the front to the back.
  typedef struct packed {
    op_e         op;
    logic [31:0] key_word;
    logic        key_last;
  } cmd_t;

  function automatic logic [31:0] fold30(input logic [31:0] v);
    fold30 = v ^ (v >> 30);
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    temper = y ^ (y >> 18);
  endfunction
endpackage

### src/mtg_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module mtg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end
endmodule

### src/mtg_front.sv
// Front end: accept requests and queue them as commands for the engine.
module mtg_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          operation_i,
  input  logic [31:0]   key_word_i,
  input  logic          key_last_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output mtg_pkg::cmd_t cmd_o
);
  import mtg_pkg::*;

  localparam int unsigned QDepth = 2;

  cmd_t       q_q [QDepth];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       in_cmd;

  assign in_ready_o  = (cnt_q != 2'(QDepth));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    in_cmd.op       = op_e'(operation_i);
    in_cmd.key_word = key_word_i;
    // Drop the last flag on a next request.
    in_cmd.key_last = operation_i & key_last_i;
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= in_cmd;
    end
  end
endmodule

### src/mtg_engine.sv
// Back end: state memory, seeding sequencer, twist and tempered output.
module mtg_engine #(
  parameter int unsigned KeyDepth = mtg_pkg::DefKeyDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          seed_we_i,
  input  logic [31:0]   seed_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  mtg_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   random_word_o
);
  import mtg_pkg::*;

  localparam int unsigned KaW = (KeyDepth > 1) ? $clog2(KeyDepth) : 1;
  localparam int unsigned KcW = $clog2(KeyDepth + 1);
  localparam int unsigned KsW = (KcW > IdxW) ? KcW : IdxW;

  typedef enum logic [3:0] {
    StIdle, StSeedS, StKeyRd, StKeyRdW, StKeyWr, StMixRd, StMixRdW,
    StMixWr, StTwRd, StTwRdW, StTwWr, StOutRd, StOutRdW, StHead
  } state_e;

  state_e            state_q;
  logic [31:0]       seed_q;
  logic [IdxW-1:0]   widx_q;
  logic              unseeded_q;
  logic [KcW-1:0]    kcnt_q;
  logic [KcW-1:0]    klen_q;
  logic [KaW-1:0]    kp_q;
  logic [KsW-1:0]    steps_q;
  logic [IdxW-1:0]   pos_q;
  logic [31:0]       prev_q;
  logic [31:0]       cur_q;
  logic [31:0]       key_q;
  logic [31:0]       prod_q;
  logic              phase2_q;
  logic              wrap_q;
  logic [31:0]       out_q;
  logic              out_valid_q;
  logic              pend_q;

  logic              sw_e;
  logic [IdxW-1:0]   sw_a, sr_a, sr_b;
  logic [31:0]       sw_d, sd_a, sd_b;
  logic              kw_e;
  logic [KaW-1:0]    kw_a, kr_a;
  logic [31:0]       kw_d, kd_a, kd_b;

  mtg_ram #(.Width(32), .Depth(Words)) u_state (
    .clk_i, .we_i(sw_e), .waddr_i(sw_a), .wdata_i(sw_d),
    .raddr_a_i(sr_a), .rdata_a_o(sd_a), .raddr_b_i(sr_b), .rdata_b_o(sd_b)
  );
  mtg_ram #(.Width(32), .Depth(KeyDepth)) u_key (
    .clk_i, .we_i(kw_e), .waddr_i(kw_a), .wdata_i(kw_d),
    .raddr_a_i(kr_a), .rdata_a_o(kd_a), .raddr_b_i(kr_a), .rdata_b_o(kd_b)
  );

  logic [IdxW-1:0] pos_n1, pos_n397;
  logic [31:0]     y_tw, seed_word, mix_word;
  logic            key_store_ok;

  assign pos_n1   = (pos_q == IdxW'(Words - 1)) ? '0 : pos_q + 1'b1;
  assign pos_n397 = (pos_q >= IdxW'(Words - ShiftOfs)) ?
                    pos_q - IdxW'(Words - ShiftOfs) : pos_q + IdxW'(ShiftOfs);
  assign key_store_ok = (kcnt_q < KcW'(KeyDepth));
  assign cmd_ready_o  = (state_q == StIdle) && !pend_q;
  assign out_valid_o  = out_valid_q;
  assign random_word_o = out_q;

  always_comb begin
    y_tw = (cur_q & HiBit) | (sd_b & LoBits);
    seed_word = prod_q + 32'(pos_q);
    mix_word  = phase2_q ? ((cur_q ^ prod_q) - 32'(pos_q))
                         : ((cur_q ^ prod_q) + key_q + 32'(kp_q));
    sw_e = 1'b0;
    sw_a = pos_q;
    sw_d = seed_word;
    sr_a = pos_q;
    sr_b = pos_n1;
    kw_e = 1'b0;
    kw_a = kcnt_q[KaW-1:0];
    kw_d = cmd_i.key_word;
    kr_a = kp_q;
    case (state_q)
      StIdle: begin
        kw_e = cmd_valid_i && cmd_ready_o && (cmd_i.op == OpKey) && key_store_ok;
        sr_a = widx_q;
        // Keep word 0 on port b, ready as the first word of a twist.
        sr_b = '0;
      end
      StSeedS: begin
        sw_e = 1'b1;
        sw_d = (pos_q == '0) ? prev_q : seed_word;
      end
      StKeyRd, StKeyRdW, StMixRd, StMixRdW: sr_a = pos_q;
      StKeyWr, StMixWr: begin
        sw_e = 1'b1;
        sw_d = mix_word;
        if (wrap_q) begin
          sw_a = '0;
          sw_d = prev_q;
        end
      end
      StHead: begin
        sw_e = 1'b1;
        sw_a = '0;
        sw_d = HiBit;
      end
      StTwRd, StTwRdW: begin
        sr_a = pos_n397;
        sr_b = pos_n1;
      end
      StTwWr: begin
        sw_e = 1'b1;
        sw_d = sd_a ^ (y_tw >> 1) ^ (y_tw[0] ? TwistXor : 32'd0);
      end
      StOutRd, StOutRdW: sr_a = widx_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      seed_q      <= SeedReset;
      widx_q      <= '0;
      unseeded_q  <= 1'b1;
      kcnt_q      <= '0;
      klen_q      <= '0;
      kp_q        <= '0;
      steps_q     <= '0;
      pos_q       <= '0;
      prev_q      <= '0;
      cur_q       <= '0;
      key_q       <= '0;
      prod_q      <= '0;
      phase2_q    <= 1'b0;
      wrap_q      <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (seed_we_i) begin
        seed_q     <= seed_i;
        unseeded_q <= 1'b1;
      end
      case (state_q)
        StIdle: begin
          if (pend_q && !out_valid_q) begin
            // Serve a request: seed and twist first where needed.
            if (unseeded_q) begin
              pos_q   <= '0;
              prev_q  <= seed_q;
              phase2_q <= 1'b0;
              state_q <= StSeedS;
            end else if (widx_q == IdxW'(Words)) begin
              pos_q   <= '0;
              state_q <= StTwRd;
            end else begin
              state_q <= StOutRdW;
            end
          end else if (cmd_valid_i && cmd_ready_o) begin
            if (cmd_i.op == OpNext) begin
              pend_q <= 1'b1;
            end else begin
              if (key_store_ok) begin
                kcnt_q <= kcnt_q + 1'b1;
              end
              if (cmd_i.key_last) begin
                klen_q   <= key_store_ok ? kcnt_q + 1'b1 : kcnt_q;
                kcnt_q   <= '0;
                pos_q    <= '0;
                prev_q   <= ArraySeed;
                phase2_q <= 1'b1;
                state_q  <= StSeedS;
              end
            end
          end
        end
        StSeedS: begin
          // Single-word recurrence, one word a cycle; prev_q holds word n-1.
          if (pos_q != '0) begin
            prev_q <= seed_word;
          end
          prod_q <= MulSeed * fold30((pos_q == '0) ? prev_q : seed_word);
          if (pos_q == IdxW'(Words - 1)) begin
            if (phase2_q) begin
              // Array seeding follows, starting from word 1.
              phase2_q <= 1'b0;
              pos_q    <= IdxW'(1);
              kp_q     <= '0;
              steps_q  <= (KsW'(klen_q) > KsW'(Words)) ? KsW'(klen_q) : KsW'(Words);
              wrap_q   <= 1'b0;
              prev_q   <= ArraySeed;
              state_q  <= StKeyRd;
            end else begin
              unseeded_q <= 1'b0;
              pos_q      <= '0;
              state_q    <= StTwRd;
            end
          end else begin
            pos_q <= pos_q + 1'b1;
          end
        end
        StKeyRd: begin
          prod_q  <= fold30(prev_q) * (phase2_q ? MulMixB : MulMixA);
          state_q <= StKeyRdW;
        end
        StKeyRdW: begin
          cur_q   <= sd_a;
          key_q   <= kd_a;
          state_q <= StKeyWr;
        end
        StKeyWr: begin
          if (wrap_q) begin
            wrap_q  <= 1'b0;
            state_q <= StKeyRd;
          end else begin
            prev_q <= mix_word;
            kp_q   <= (KcW'(kp_q) + 1'b1 >= klen_q) ? '0 : kp_q + 1'b1;
            steps_q <= steps_q - 1'b1;
            if (pos_q == IdxW'(Words - 1)) begin
              pos_q  <= IdxW'(1);
              wrap_q <= 1'b1;
            end else begin
              pos_q <= pos_q + 1'b1;
            end
            if (steps_q == KsW'(1)) begin
              steps_q  <= KsW'(Words - 1);
              phase2_q <= 1'b1;
              state_q  <= (pos_q == IdxW'(Words - 1)) ? StKeyWr : StMixRd;
            end else if (pos_q != IdxW'(Words - 1)) begin
              state_q <= StKeyRd;
            end
          end
        end
        StMixRd: begin
          prod_q  <= fold30(prev_q) * MulMixB;
          state_q <= StMixRdW;
        end
        StMixRdW: begin
          cur_q   <= sd_a;
          state_q <= StMixWr;
        end
        StMixWr: begin
          if (wrap_q) begin
            wrap_q  <= 1'b0;
            state_q <= (steps_q == '0) ? StHead : StMixRd;
          end else begin
            prev_q  <= mix_word;
            steps_q <= steps_q - 1'b1;
            if (pos_q == IdxW'(Words - 1)) begin
              pos_q  <= IdxW'(1);
              wrap_q <= 1'b1;
            end else begin
              pos_q <= pos_q + 1'b1;
              state_q <= (steps_q == KsW'(1)) ? StHead : StMixRd;
            end
          end
        end
        StHead: begin
          phase2_q   <= 1'b0;
          unseeded_q <= 1'b0;
          widx_q     <= IdxW'(Words);
          state_q    <= StIdle;
        end
        StTwRd: begin
          // Port b still holds word n from the previous cycle.
          cur_q   <= sd_b;
          state_q <= StTwRdW;
        end
        StTwRdW: state_q <= StTwWr;
        StTwWr: begin
          if (pos_q == IdxW'(Words - 1)) begin
            widx_q  <= '0;
            state_q <= StOutRd;
          end else begin
            pos_q   <= pos_q + 1'b1;
            state_q <= StTwRd;
          end
        end
        StOutRd: state_q <= StOutRdW;
        StOutRdW: begin
          out_q       <= temper(sd_a);
          out_valid_q <= 1'b1;
          pend_q      <= 1'b0;
          widx_q      <= widx_q + 1'b1;
          state_q     <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

### src/mersenne_twister_generator.sv
// Top level: MT19937 generator with single-word and key-array seeding.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  request  | in_valid_i / in_ready_o | operation_i, key_word_i, key_last_i
//  result   | out_valid_o/out_ready_i | random_word_o
//  seed reg | seed_we_i               | seed_i
//
// A front queue (two entries) takes requests; the engine runs one at a time.
// A next request on seeded state is served from the word that StIdle already
// reads, through the registered read of the single state memory. A twist
// passes each word through StTwRd, StTwRdW and StTwWr; array seeding follows
// its single-word base seeding with a key pass of max(key count, 624) words
// and a mix pass of 623, each word through a read, a wait and a write state.
// Reset leaves the state unseeded and the seed at 5489; no clearing pass.
// A waiting result holds the engine once it holds a next request; the front
// queue then fills and drops in_ready_o.
module mersenne_twister_generator #(
  parameter int unsigned KeyDepth = mtg_pkg::DefKeyDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [31:0] key_word_i,
  input  logic        key_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] random_word_o,
  input  logic        seed_we_i,
  input  logic [31:0] seed_i
);
  import mtg_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  // Classify and queue each request.
  mtg_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .key_word_i,
    .key_last_i, .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  // Seed, twist and temper.
  mtg_engine #(.KeyDepth(KeyDepth)) u_engine (
    .clk_i, .rst_ni, .seed_we_i, .seed_i, .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready), .cmd_i(cmd), .out_valid_o, .out_ready_i,
    .random_word_o
  );
endmodule
